// ===== src/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-512 package
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package sha512_pkg;
    localparam int NumRounds = 80;
    localparam int BlockBytes = 128;

    typedef logic [63:0] t_word;

    function automatic t_word round_k(input logic [6:0] t);
        case (t)
            7'd0: round_k = 64'h428a2f98d728ae22; 7'd1: round_k = 64'h7137449123ef65cd;
            7'd2: round_k = 64'hb5c0fbcfec4d3b2f; 7'd3: round_k = 64'he9b5dba58189dbbc;
            7'd4: round_k = 64'h3956c25bf348b538; 7'd5: round_k = 64'h59f111f1b605d019;
            7'd6: round_k = 64'h923f82a4af194f9b; 7'd7: round_k = 64'hab1c5ed5da6d8118;
            7'd8: round_k = 64'hd807aa98a3030242; 7'd9: round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = 64'h0;
        endcase
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 64'h6a09e667f3bcc908;
            3'd1: init_h = 64'hbb67ae8584caa73b;
            3'd2: init_h = 64'h3c6ef372fe94f82b;
            3'd3: init_h = 64'ha54ff53a5f1d36f1;
            3'd4: init_h = 64'h510e527fade682d1;
            3'd5: init_h = 64'h9b05688c2b3e6c1f;
            3'd6: init_h = 64'h1f83d9abfb41bd6b;
            3'd7: init_h = 64'h5be0cd19137e2179;
            default: init_h = 64'h0;
        endcase
    endfunction

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction
endpackage
`default_nettype wire

// ===== src/sha512_core.sv =====
// ----------------------------------------------------------------------------
// SHA-512 round core
// One shared round unit iterated over 80 rounds; reads words from the buffer.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_core (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [63:0]           i_w,
    output logic [3:0]            o_word_addr,
    input  wire  [511:0]          i_hash,
    output logic [511:0]          o_hash,
    output logic                  o_done
);
    localparam logic [1:0] P_IDLE = 2'd0, P_ROUND = 2'd1, P_FINAL = 2'd2;

    logic [63:0] r_v [8];
    logic [63:0] r_win [16];
    logic [6:0]  r_t;
    logic [1:0]  r_ph;
    logic [63:0] w, x2, x15, t1, t2;
    logic [3:0]  t4;

    assign t4 = r_t[3:0];
    assign o_word_addr = t4;
    assign x2 = r_win[t4 - 4'd2];
    assign x15 = r_win[t4 - 4'd15];

    always_comb begin
        if (r_t < 7'd16) begin
            w = i_w;
        end else begin
            w = (sha512_pkg::rotr(x2, 19) ^ sha512_pkg::rotr(x2, 61) ^ (x2 >> 6))
              + r_win[t4 - 4'd7]
              + (sha512_pkg::rotr(x15, 1) ^ sha512_pkg::rotr(x15, 8) ^ (x15 >> 7))
              + r_win[t4];
        end
        t1 = r_v[7] + (sha512_pkg::rotr(r_v[4], 14) ^ sha512_pkg::rotr(r_v[4], 18)
             ^ sha512_pkg::rotr(r_v[4], 41)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha512_pkg::round_k(r_t) + w;
        t2 = (sha512_pkg::rotr(r_v[0], 28) ^ sha512_pkg::rotr(r_v[0], 34)
             ^ sha512_pkg::rotr(r_v[0], 39))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_ph <= P_IDLE;
            r_t <= 7'd0;
        end else if (i_start) begin
            r_ph <= P_ROUND;
            r_t <= 7'd0;
            for (int j = 0; j < 8; j++) r_v[j] <= i_hash[511 - 64*j -: 64];
        end else if (r_ph == P_ROUND) begin
            r_win[t4] <= w;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            if (r_t == 7'(sha512_pkg::NumRounds - 1)) r_ph <= P_FINAL;
            r_t <= r_t + 7'd1;
        end else if (r_ph == P_FINAL) begin
            for (int j = 0; j < 8; j++)
                o_hash[511 - 64*j -: 64] <= i_hash[511 - 64*j -: 64] + r_v[j];
            r_ph <= P_IDLE;
            o_done <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== src/sha512_hash_engine.sv =====
// ----------------------------------------------------------------------------
// SHA-512 hash engine
// Byte-wise message input, block buffering, padding and digest output.
// One byte per cycle while idle; input stalls in every other state. A byte
// that fills a block starts compression. An end item pads from the fill
// position to the block end and compresses, then a second padded block if
// needed, then 8 digest transfers. Reset (sync, active low) loads initial hash values.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_hash_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_message_byte,
    input  wire         i_byte_present,
    input  wire         i_end_of_message,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_COMP = 3'd2, S_OUT = 3'd3;

    logic [2:0]   r_st;
    logic [63:0]  r_buf [16];
    logic [6:0]   r_fill;
    logic [7:0]   r_pi;
    logic [63:0]  r_bits, r_total;
    logic [511:0] r_hash;
    logic         r_end, r_end_pend, r_last_comp, r_two;
    logic [2:0]   r_oi;
    logic         r_start;
    logic [3:0]   addr;
    logic [63:0]  wrd;
    logic [511:0] c_hash;
    logic         c_done;
    logic         acc;
    logic         blk_full;
    logic [6:0]   new_fill;
    logic [7:0]   pad_byte;

    assign o_stall = (r_st != S_IDLE);
    assign acc = i_valid && !o_stall;
    assign blk_full = i_byte_present && (r_fill == 7'd127);
    assign new_fill = r_fill + {6'd0, i_byte_present};
    assign wrd = r_buf[addr];

    sha512_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_w(wrd),
        .o_word_addr(addr), .i_hash(r_hash), .o_hash(c_hash), .o_done(c_done)
    );

    // padding byte at position r_pi
    always_comb begin
        if (!r_two && r_pi[6:0] == r_fill) pad_byte = 8'h80;
        else if (r_pi >= 8'd120 && (r_two || r_fill <= 7'd111))
            pad_byte = r_total[63 - 8*r_pi[2:0] -: 8];
        else pad_byte = 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_fill <= 7'd0;
            r_bits <= 64'd0;
            r_start <= 1'b0;
            r_end <= 1'b0;
            r_end_pend <= 1'b0;
            r_two <= 1'b0;
            r_oi <= 3'd0;
            o_valid <= 1'b0;
            for (int j = 0; j < 8; j++) r_hash[511 - 64*j -: 64] <= sha512_pkg::init_h(3'(j));
        end else begin
            r_start <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (acc) begin
                        if (i_byte_present) begin
                            r_buf[r_fill[6:3]][63 - 8*r_fill[2:0] -: 8] <= i_message_byte;
                        end
                        r_fill <= new_fill;
                        r_two <= 1'b0;
                        r_pi <= {1'b0, new_fill};
                        r_total <= r_bits + {54'd0, new_fill, 3'd0};
                        r_end <= i_end_of_message && !blk_full;
                        r_end_pend <= i_end_of_message && blk_full;
                        if (blk_full) begin
                            r_start <= 1'b1;
                            r_last_comp <= 1'b0;
                            r_st <= S_COMP;
                        end else if (i_end_of_message) begin
                            r_st <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_buf[r_pi[6:3]][63 - 8*r_pi[2:0] -: 8] <= pad_byte;
                    r_pi <= r_pi + 8'd1;
                    if (r_pi == 8'd127) begin
                        r_start <= 1'b1;
                        r_last_comp <= r_two || (r_fill <= 7'd111);
                        r_st <= S_COMP;
                    end
                end
                S_COMP: begin
                    if (c_done) begin
                        r_hash <= c_hash;
                        if (!r_end) begin
                            r_bits <= r_bits + 64'd1024;
                            r_fill <= 7'd0;
                            if (r_end_pend) begin
                                // end item whose byte completed a block
                                r_end <= 1'b1;
                                r_end_pend <= 1'b0;
                                r_two <= 1'b0;
                                r_pi <= 8'd0;
                                r_total <= r_bits + 64'd1024;
                                r_st <= S_PAD;
                            end else begin
                                r_st <= S_IDLE;
                            end
                        end else if (r_last_comp) begin
                            r_oi <= 3'd0;
                            o_valid <= 1'b1;
                            r_st <= S_OUT;
                        end else begin
                            r_two <= 1'b1;
                            r_pi <= 8'd0;
                            r_st <= S_PAD;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            o_valid <= 1'b0;
                            r_fill <= 7'd0;
                            r_bits <= 64'd0;
                            for (int j = 0; j < 8; j++)
                                r_hash[511 - 64*j -: 64] <= sha512_pkg::init_h(3'(j));
                            r_st <= S_IDLE;
                        end
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_digest_word = r_hash[511 - 64*r_oi -: 64];
    assign o_word_index = r_oi;
    assign o_last_word = (r_oi == 3'd7);
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// SHA-512 hash engine testbench
// Sends messages byte by byte, predicts each digest with a local SHA-512
// model and compares every digest word as it leaves the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_message_byte = 8'd0;
    logic        i_byte_present = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_out;

    t_digest_out digest_q[$];
    int          errors = 0;
    int          words_seen = 0;
    int          messages_sent = 0;
    int          items_sent = 0;
    bit          hold_off = 1'b0;
    bit          burst_mode = 1'b1;

    sha512_pkg::t_word hash_state[8];
    logic [7:0]  pend_buf[128];
    int          pend_count;
    logic [63:0] done_bits;

    sha512_hash_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_message_byte(i_message_byte), .i_byte_present(i_byte_present),
        .i_end_of_message(i_end_of_message),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic sha512_pkg::t_word ror64(sha512_pkg::t_word x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic hash_reload();
        for (int j = 0; j < 8; j++) hash_state[j] = sha512_pkg::init_h(j[2:0]);
        pend_count = 0;
        done_bits = 64'd0;
    endtask

    task automatic compress_pending();
        sha512_pkg::t_word w[80];
        sha512_pkg::t_word v[8];
        sha512_pkg::t_word t1, t2;
        for (int t = 0; t < 16; t++) begin
            w[t] = 64'd0;
            for (int j = 0; j < 8; j++)
                w[t] = (w[t] << 8) | sha512_pkg::t_word'(pend_buf[t * 8 + j]);
        end
        for (int t = 16; t < 80; t++)
            w[t] = (ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6)) + w[t-7]
                 + (ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7)) + w[t-16];
        for (int j = 0; j < 8; j++) v[j] = hash_state[j];
        for (int t = 0; t < 80; t++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::round_k(t[6:0]) + w[t];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) hash_state[j] += v[j];
    endtask

    task automatic predict_digest(logic [7:0] b, logic present, logic fin);
        logic [63:0] total;
        int k;
        if (present) begin
            pend_buf[pend_count] = b;
            pend_count++;
            if (pend_count == 128) begin
                compress_pending();
                done_bits += 64'd1024;
                pend_count = 0;
            end
        end
        if (!fin) return;
        total = done_bits + 64'(pend_count) * 64'd8;
        k = pend_count;
        pend_buf[k++] = 8'h80;
        if (k > 112) begin
            while (k < 128) pend_buf[k++] = 8'h00;
            compress_pending();
            k = 0;
        end
        while (k < 120) pend_buf[k++] = 8'h00;
        for (int j = 0; j < 8; j++) pend_buf[120 + j] = total[63 - 8 * j -: 8];
        compress_pending();
        for (int j = 0; j < 8; j++)
            digest_q.push_back('{hash_state[j], j[2:0], j == 7});
        hash_reload();
    endtask

    task automatic send_item(logic [7:0] b, logic present, logic fin);
        int gap;
        if (burst_mode && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_message_byte <= b;
        i_byte_present <= present;
        i_end_of_message <= fin;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_digest(b, present, fin);
        items_sent++;
        if (fin) messages_sent++;
    endtask

    task automatic send_message(int len, bit bare_end);
        for (int j = 0; j < len; j++)
            send_item(8'($urandom_range(0, 255)), 1'b1, !bare_end && j == len - 1);
        if (bare_end || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) i_stall <= 1'b0 | hold_off;
        else i_stall <= ($urandom_range(0, 3) == 0) && ((words_seen / 16) % 2 == 0);
    end

    always @(posedge i_clk) begin
        t_digest_out exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            words_seen++;
            if (digest_q.size() == 0) begin
                $display("%0t unexpected word: actual %h idx %0d", $time,
                         o_digest_word, o_word_index);
                errors++;
            end else begin
                exp_w = digest_q.pop_front();
                if (exp_w.word !== o_digest_word || exp_w.index !== o_word_index ||
                    exp_w.last !== o_last_word) begin
                    $display("%0t mismatch: expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                             exp_w.word, exp_w.index, exp_w.last,
                             o_digest_word, o_word_index, o_last_word);
                    errors++;
                end
            end
        end
    end

    task automatic test_empty_and_bare();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        drain();
    endtask

    task automatic test_padding_edges();
        send_message(112, 1'b0);
        send_message(128, 1'b0);
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            begin
                send_message(3, 1'b0);
                send_message(5, 1'b1);
                send_message(2, 1'b0);
            end
        join
        drain();
    endtask

    task automatic test_random_messages();
        int len;
        int sel;
        while (items_sent < 300) begin
            burst_mode = $urandom_range(0, 3) != 0;
            sel = $urandom_range(0, 9);
            len = (sel == 0) ? $urandom_range(30, 60) : $urandom_range(0, 20);
            if (sel == 1) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_message(len, $urandom_range(0, 3) == 0);
        end
        burst_mode = 1'b1;
        drain();
    endtask

    initial begin
        hash_reload();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_and_bare();
        test_padding_edges();
        test_backpressure();
        test_random_messages();
        $display("covered %0d items, %0d messages, %0d digest words", items_sent,
                 messages_sent, words_seen);
        $display("including empty, bare-end, padding-boundary and stalled-output cases");
        if (errors == 0 && digest_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sha512_hash_engine.f =====
src/sha512_pkg.sv
src/sha512_core.sv
src/sha512_hash_engine.sv
tb/tb.sv
